// ===== hw/rtl/gcd_pkg.sv =====
package gcd_pkg;

	localparam int ANGLE_BITS    = 32;
	localparam int CORDIC_STAGES = 30;
	localparam int QW            = 36;

	typedef logic signed [QW-1:0] qw_t;

	typedef struct packed {
		logic flip;
		qw_t  z;
	} rot_in_t;

	localparam logic [31:0] ANGLE_KEEP = ~((32'd1 << (32 - ANGLE_BITS)) - 32'd1);
	localparam logic [31:0] PI_Q30      = 32'hC90FDAA2;
	localparam qw_t         HALF_PI_Q30 = 36'sd1686629713;
	localparam qw_t         INV_GAIN    = 36'sd652032874;
	localparam logic [22:0] RADIUS_RST  = 23'd6372795;
	localparam logic [24:0] DIST_MAX    = 25'd33554431;

	localparam qw_t ATAN_TAB [32] = '{
		36'sd843314857, 36'sd497837829, 36'sd263043837, 36'sd133525159,
		36'sd67021687,  36'sd33543516,  36'sd16775851,  36'sd8388437,
		36'sd4194283,   36'sd2097149,   36'sd1048576,   36'sd524288,
		36'sd262144,    36'sd131072,    36'sd65536,     36'sd32768,
		36'sd16384,     36'sd8192,      36'sd4096,      36'sd2048,
		36'sd1024,      36'sd512,       36'sd256,       36'sd128,
		36'sd64,        36'sd32,        36'sd16,        36'sd8,
		36'sd4,         36'sd2,         36'sd1,         36'sd1
	};

	// Q6.30 product: round the magnitude half up, then restore the sign.
	function automatic qw_t mulq(qw_t a, qw_t b);
		logic [QW-1:0]   ma;
		logic [QW-1:0]   mb;
		logic [2*QW-1:0] p;
		logic [QW-1:0]   r;
		logic            neg;
		ma  = a[QW-1] ? QW'(-a) : QW'(a);
		mb  = b[QW-1] ? QW'(-b) : QW'(b);
		neg = a[QW-1] ^ b[QW-1];
		p   = ma * mb + (2*QW)'(64'd1 << 29);
		r   = p[QW+29:30];
		return neg ? qw_t'(-r) : qw_t'(r);
	endfunction

	// Binary angle to radians, folded into +-pi/2.
	function automatic rot_in_t angle_in(logic [31:0] ang);
		rot_in_t     o;
		logic [31:0] a;
		logic [31:0] m;
		logic [63:0] p;
		a      = ang;
		o.flip = ($signed(a) > 32'sd1073741824) || ($signed(a) < -32'sd1073741824);
		if (o.flip) begin
			a = a - 32'h8000_0000;
		end
		m   = a[31] ? 32'(-a) : a;
		p   = m * PI_Q30 + 64'h4000_0000;
		o.z = a[31] ? -qw_t'({1'b0, p[62:31]}) : qw_t'({1'b0, p[62:31]});
		return o;
	endfunction

endpackage

// ===== hw/rtl/gcd_cordic_rot.sv =====
module gcd_cordic_rot (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           valid_i,
	input  gcd_pkg::rot_in_t ang_i,
	output logic           valid_o,
	output gcd_pkg::qw_t   sin_o,
	output gcd_pkg::qw_t   cos_o
);

	localparam int N = gcd_pkg::CORDIC_STAGES;

	logic         v_s    [N+1];
	logic         flip_s [N+1];
	gcd_pkg::qw_t x_s    [N+1];
	gcd_pkg::qw_t y_s    [N+1];
	gcd_pkg::qw_t z_s    [N+1];

	assign v_s[0]    = valid_i;
	assign flip_s[0] = ang_i.flip;
	assign x_s[0]    = gcd_pkg::INV_GAIN;
	assign y_s[0]    = '0;
	assign z_s[0]    = ang_i.z;

	for (genvar i = 0; i < N; i++) begin : g_stage
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i+1] <= 1'b0;
			end else if (en) begin
				v_s[i+1] <= v_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				flip_s[i+1] <= flip_s[i];
				if (!z_s[i][gcd_pkg::QW-1]) begin
					x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] - gcd_pkg::ATAN_TAB[i];
				end else begin
					x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] + gcd_pkg::ATAN_TAB[i];
				end
			end
		end
	end

	assign valid_o = v_s[N];
	assign sin_o   = flip_s[N] ? -y_s[N] : y_s[N];
	assign cos_o   = flip_s[N] ? -x_s[N] : x_s[N];

endmodule

// ===== hw/rtl/gcd_cordic_vec.sv =====
module gcd_cordic_vec (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         en,
	input  logic         valid_i,
	input  gcd_pkg::qw_t x_i,
	input  gcd_pkg::qw_t y_i,
	input  gcd_pkg::qw_t z_i,
	input  gcd_pkg::qw_t side_i,
	output logic         valid_o,
	output gcd_pkg::qw_t x_o,
	output gcd_pkg::qw_t z_o,
	output gcd_pkg::qw_t side_o
);

	localparam int N = gcd_pkg::CORDIC_STAGES;

	logic         v_s    [N+1];
	gcd_pkg::qw_t x_s    [N+1];
	gcd_pkg::qw_t y_s    [N+1];
	gcd_pkg::qw_t z_s    [N+1];
	gcd_pkg::qw_t side_s [N+1];

	assign v_s[0]    = valid_i;
	assign x_s[0]    = x_i;
	assign y_s[0]    = y_i;
	assign z_s[0]    = z_i;
	assign side_s[0] = side_i;

	for (genvar i = 0; i < N; i++) begin : g_stage
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i+1] <= 1'b0;
			end else if (en) begin
				v_s[i+1] <= v_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				side_s[i+1] <= side_s[i];
				if (!y_s[i][gcd_pkg::QW-1]) begin
					x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] + gcd_pkg::ATAN_TAB[i];
				end else begin
					x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] - gcd_pkg::ATAN_TAB[i];
				end
			end
		end
	end

	assign valid_o = v_s[N];
	assign x_o     = x_s[N];
	assign z_o     = z_s[N];
	assign side_o  = side_s[N];

endmodule

// ===== hw/rtl/great_circle_distance_core.sv =====
// Great-circle distance between two points given as binary angles (2^31 = pi).
// Request channel: req_valid/req_ready with lat_a, lon_a, lat_b, lon_b.
// Response channel: rsp_valid/rsp_ready with distance_m in metres, saturated.
// Configuration: cfg_we writes cfg_wdata into the earth radius register; write
// it only while no transaction is in flight.
// Throughput: one transaction per cycle while the output is not stalled. Results
// pass through three chained CORDIC pipelines (sine/cosine,
// root, arctangent) plus the multiply stages between them.
// Reset clears every stage valid bit and loads the radius with 6372795.
// When the receiver holds rsp_ready low with a result waiting, the whole
// pipeline freezes and req_ready drops in the same cycle; nothing is lost
// or repeated, and flow resumes as soon as rsp_ready returns.
module great_circle_distance_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_ready,
	input  logic [31:0] lat_a,
	input  logic [31:0] lon_a,
	input  logic [31:0] lat_b,
	input  logic [31:0] lon_b,
	output logic        rsp_valid,
	input  logic        rsp_ready,
	output logic [24:0] distance_m,
	input  logic        cfg_we,
	input  logic [22:0] cfg_wdata
);

	logic        en;
	logic [22:0] radius_q;

	logic             v_s1;
	gcd_pkg::rot_in_t ra_s1, rb_s1, rd_s1;

	logic         rot_v;
	gcd_pkg::qw_t s1, c1, s2, c2, sd, cd;

	logic         v_s2;
	gcd_pkg::qw_t t1_s2, m1_s2, m2_s2, c12_s2, m3_s2, cd_s2;
	logic         v_s3;
	gcd_pkg::qw_t t1_s3, m1_s3, m3_s3, p2_s3, p3_s3;
	logic         v_s4;
	gcd_pkg::qw_t a1_s4, a2_s4, t3_s4;

	logic         vec1_v;
	gcd_pkg::qw_t vec1_x, vec1_z, vec1_t3;

	logic         v_s5;
	gcd_pkg::qw_t h_s5, t3_s5;
	logic         v_s6;
	gcd_pkg::qw_t x_s6, y_s6, z_s6;

	logic         vec2_v;
	gcd_pkg::qw_t vec2_x, vec2_z;

	logic        v_s7;
	logic [55:0] prod_s7;
	logic        v_s8;
	logic [24:0] dist_s8;
	logic [25:0] rnd;

	assign en        = !v_s8 || rsp_ready;
	assign req_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= gcd_pkg::RADIUS_RST;
		end else if (cfg_we) begin
			radius_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
		end else if (en) begin
			v_s1 <= req_valid;
			v_s2 <= rot_v;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= vec1_v;
			v_s6 <= v_s5;
			v_s7 <= vec2_v;
			v_s8 <= v_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ra_s1 <= gcd_pkg::angle_in(lat_a & gcd_pkg::ANGLE_KEEP);
			rb_s1 <= gcd_pkg::angle_in(lat_b & gcd_pkg::ANGLE_KEEP);
			rd_s1 <= gcd_pkg::angle_in((lon_b & gcd_pkg::ANGLE_KEEP)
				- (lon_a & gcd_pkg::ANGLE_KEEP));
		end
	end

	gcd_cordic_rot u_rot_a (
		.clk(clk), .arst_n(arst_n), .en(en), .valid_i(v_s1), .ang_i(ra_s1),
		.valid_o(rot_v), .sin_o(s1), .cos_o(c1)
	);

	gcd_cordic_rot u_rot_b (
		.clk(clk), .arst_n(arst_n), .en(en), .valid_i(v_s1), .ang_i(rb_s1),
		.valid_o(), .sin_o(s2), .cos_o(c2)
	);

	gcd_cordic_rot u_rot_d (
		.clk(clk), .arst_n(arst_n), .en(en), .valid_i(v_s1), .ang_i(rd_s1),
		.valid_o(), .sin_o(sd), .cos_o(cd)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			t1_s2  <= gcd_pkg::mulq(c2, sd);
			m1_s2  <= gcd_pkg::mulq(c1, s2);
			m2_s2  <= gcd_pkg::mulq(s1, c2);
			c12_s2 <= gcd_pkg::mulq(c1, c2);
			m3_s2  <= gcd_pkg::mulq(s1, s2);
			cd_s2  <= cd;

			t1_s3 <= t1_s2;
			m1_s3 <= m1_s2;
			m3_s3 <= m3_s2;
			p2_s3 <= gcd_pkg::mulq(m2_s2, cd_s2);
			p3_s3 <= gcd_pkg::mulq(c12_s2, cd_s2);

			a1_s4 <= t1_s3[gcd_pkg::QW-1] ? -t1_s3 : t1_s3;
			a2_s4 <= (m1_s3 - p2_s3 < 0) ? p2_s3 - m1_s3 : m1_s3 - p2_s3;
			t3_s4 <= m3_s3 + p3_s3;
		end
	end

	gcd_cordic_vec u_vec_root (
		.clk(clk), .arst_n(arst_n), .en(en), .valid_i(v_s4),
		.x_i(a1_s4), .y_i(a2_s4), .z_i('0), .side_i(t3_s4),
		.valid_o(vec1_v), .x_o(vec1_x), .z_o(vec1_z), .side_o(vec1_t3)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			h_s5  <= gcd_pkg::mulq(vec1_x, gcd_pkg::INV_GAIN);
			t3_s5 <= vec1_t3;
			// Turn a vector in the left half plane by a quarter before vectoring.
			if (t3_s5[gcd_pkg::QW-1]) begin
				x_s6 <= h_s5;
				y_s6 <= -t3_s5;
				z_s6 <= gcd_pkg::HALF_PI_Q30;
			end else begin
				x_s6 <= t3_s5;
				y_s6 <= h_s5;
				z_s6 <= '0;
			end
		end
	end

	gcd_cordic_vec u_vec_atan (
		.clk(clk), .arst_n(arst_n), .en(en), .valid_i(v_s6),
		.x_i(x_s6), .y_i(y_s6), .z_i(z_s6), .side_i(vec1_z),
		.valid_o(vec2_v), .x_o(vec2_x), .z_o(vec2_z), .side_o()
	);

	assign rnd = 26'((prod_s7 + 56'd536870912) >> 30);

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s7 <= vec2_z[gcd_pkg::QW-1] ? 56'd0
				: 56'(vec2_z[32:0]) * 56'(radius_q);
			dist_s8 <= (rnd > 26'(gcd_pkg::DIST_MAX)) ? gcd_pkg::DIST_MAX : rnd[24:0];
		end
	end

	assign rsp_valid  = v_s8;
	assign distance_m = dist_s8;

endmodule

// ===== hw/rtl/gcd_checker.sv =====
module gcd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        req_ready,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic [24:0] distance_m
);

	// Hold a stalled response.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(distance_m))
		else $error("stalled response changed");

	// Stall the request side while a response waits.
	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |-> !req_ready)
		else $error("request taken during output stall");

	// Accept requests whenever the output is free.
	a_no_idle_block: assert property (@(posedge clk) disable iff (!arst_n)
		!rsp_valid || rsp_ready |-> req_ready)
		else $error("request refused with free output");

endmodule

bind great_circle_distance_core gcd_checker u_gcd_checker (
	.clk(clk), .arst_n(arst_n), .req_ready(req_ready),
	.rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .distance_m(distance_m)
);

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps

class distance_scoreboard;
	logic [24:0] pending_dist[$];
	int n_errors;
	int n_checked;

	function new();
		n_errors = 0;
		n_checked = 0;
	endfunction

	function void note_request(logic [24:0] predicted);
		pending_dist.push_back(predicted);
	endfunction

	function void check_distance(logic [24:0] actual);
		logic [24:0] want;
		if (pending_dist.size() == 0) begin
			$error("distance_m: no transaction pending, actual %0d", actual);
			n_errors++;
		end else begin
			want = pending_dist.pop_front();
			n_checked++;
			if (want !== actual) begin
				$error("distance_m: expected %0d actual %0d", want, actual);
				n_errors++;
			end
		end
	endfunction
endclass

module tb_top;

	localparam int LATENCY = 3 * gcd_pkg::CORDIC_STAGES + 8;
	localparam int N_RANDOM = 625;

	logic        clk;
	logic        arst_n;
	logic        req_valid;
	logic        req_ready;
	logic [31:0] lat_a;
	logic [31:0] lon_a;
	logic [31:0] lat_b;
	logic [31:0] lon_b;
	logic        rsp_valid;
	logic        rsp_ready;
	logic [24:0] distance_m;
	logic        cfg_we;
	logic [22:0] cfg_wdata;

	distance_scoreboard sb;
	logic [63:0] arc_tab[32];
	logic [22:0] radius;
	int          n_sent;
	bit          rx_steady;
	bit          rx_hold;

	great_circle_distance_core i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.lat_a     (lat_a),
		.lon_a     (lon_a),
		.lat_b     (lat_b),
		.lon_b     (lon_b),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.distance_m(distance_m),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always #4 clk = ~clk;

	function automatic longint asr64(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint q30_mul(longint a, longint b);
		bit       neg;
		longint   ma;
		longint   mb;
		longint   p;
		neg = (a < 0) != (b < 0);
		ma = a < 0 ? -a : a;
		mb = b < 0 ? -b : b;
		p = (ma * mb + (64'sd1 <<< 29)) >>> 30;
		return neg ? -p : p;
	endfunction

	task automatic rotate_sincos(input logic [31:0] ang, output longint s, output longint c);
		bit          flip;
		logic [31:0] a;
		longint      m;
		longint      x;
		longint      y;
		longint      z;
		longint      nx;
		a = ang;
		flip = ($signed(a) > 32'sd1073741824) || ($signed(a) < -32'sd1073741824);
		if (flip) begin
			a = a - 32'h8000_0000;
		end
		m = a[31] ? longint'(-{32'd0, a} & 64'hFFFF_FFFF) : longint'({32'd0, a});
		if (a[31]) begin
			m = longint'(33'h1_0000_0000 - {1'b0, a});
		end
		m = (m * longint'({32'd0, gcd_pkg::PI_Q30}) + (64'sd1 <<< 30)) >>> 31;
		z = a[31] ? -m : m;
		x = gcd_pkg::INV_GAIN;
		y = 0;
		for (int i = 0; i < gcd_pkg::CORDIC_STAGES; i++) begin
			if (z >= 0) begin
				nx = x - asr64(y, i);
				y = y + asr64(x, i);
				z -= arc_tab[i];
			end else begin
				nx = x + asr64(y, i);
				y = y - asr64(x, i);
				z += arc_tab[i];
			end
			x = nx;
		end
		s = flip ? -y : y;
		c = flip ? -x : x;
	endtask

	task automatic vectorize(inout longint x, inout longint y, inout longint z);
		longint nx;
		for (int i = 0; i < gcd_pkg::CORDIC_STAGES; i++) begin
			if (y >= 0) begin
				nx = x + asr64(y, i);
				y = y - asr64(x, i);
				z += arc_tab[i];
			end else begin
				nx = x - asr64(y, i);
				y = y + asr64(x, i);
				z -= arc_tab[i];
			end
			x = nx;
		end
	endtask

	task automatic predict_distance(input logic [31:0] la, input logic [31:0] oa,
		input logic [31:0] lb, input logic [31:0] ob, output logic [24:0] want_dist);
		longint s1, c1, s2, c2, sd, cd, t1, t2, t3, h, x, y, z;
		logic [63:0] prod;
		logic [31:0] dlon;
		la &= gcd_pkg::ANGLE_KEEP;
		oa &= gcd_pkg::ANGLE_KEEP;
		lb &= gcd_pkg::ANGLE_KEEP;
		ob &= gcd_pkg::ANGLE_KEEP;
		dlon = ob - oa;
		rotate_sincos(la, s1, c1);
		rotate_sincos(lb, s2, c2);
		rotate_sincos(dlon, sd, cd);
		t1 = q30_mul(c2, sd);
		t2 = q30_mul(c1, s2) - q30_mul(q30_mul(s1, c2), cd);
		t3 = q30_mul(s1, s2) + q30_mul(q30_mul(c1, c2), cd);
		x = t1 < 0 ? -t1 : t1;
		y = t2 < 0 ? -t2 : t2;
		z = 0;
		vectorize(x, y, z);
		h = q30_mul(x, gcd_pkg::INV_GAIN);
		if (t3 < 0) begin
			x = h;
			y = -t3;
			z = gcd_pkg::HALF_PI_Q30;
		end else begin
			x = t3;
			y = h;
			z = 0;
		end
		vectorize(x, y, z);
		if (z < 0) begin
			z = 0;
		end
		prod = (z * longint'({41'd0, radius}) + (64'sd1 <<< 29)) >> 30;
		want_dist = prod > 64'(gcd_pkg::DIST_MAX) ? gcd_pkg::DIST_MAX : prod[24:0];
	endtask

	// valid stays high after acceptance; the caller drops it when idling
	task automatic send_points(input logic [31:0] la, input logic [31:0] oa,
		input logic [31:0] lb, input logic [31:0] ob);
		logic [24:0] want;
		predict_distance(la, oa, lb, ob, want);
		req_valid <= 1'b1;
		lat_a <= la;
		lon_a <= oa;
		lat_b <= lb;
		lon_b <= ob;
		do @(posedge clk); while (!req_ready);
		sb.note_request(want);
		n_sent++;
	endtask

	task automatic send_maybe_idle(input logic [31:0] la, input logic [31:0] oa,
		input logic [31:0] lb, input logic [31:0] ob, input bit steady);
		if (!steady) begin
			while ($urandom_range(99) < 16) begin
				req_valid <= 1'b0;
				@(posedge clk);
			end
		end
		send_points(la, oa, lb, ob);
	endtask

	task automatic drain_then_write(input logic [22:0] r);
		req_valid <= 1'b0;
		while (sb.pending_dist.size() != 0) begin
			@(posedge clk);
		end
		repeat (4) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= r;
		@(posedge clk);
		cfg_we <= 1'b0;
		radius = r;
	endtask

	function automatic logic [31:0] rand_lat();
		int unsigned pick;
		pick = $urandom_range(9);
		if (pick == 0) begin
			return 32'h4000_0000;
		end else if (pick == 1) begin
			return 32'hC000_0000;
		end else if (pick == 2) begin
			return $urandom();
		end
		return 32'($signed($urandom_range(32'h7FFF_FFFF, 0)) - 32'sh4000_0000);
	endfunction

	// receiver: random stalls, a long hold-off, then a steady stretch
	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_valid && rsp_ready) begin
				sb.check_distance(distance_m);
			end
			rsp_ready <= rx_hold ? 1'b0 : (rx_steady ? 1'b1 : ($urandom_range(99) >= 16));
		end
	end

	initial begin
		int steps;
		rx_hold = 1'b0;
		wait (n_sent >= 150);
		rx_hold = 1'b1;
		steps = 0;
		while (steps < 300) begin
			@(posedge clk);
			steps++;
		end
		rx_hold = 1'b0;
	end

	initial begin
		#20ms;
		$display("Test completed with failures");
		$finish;
	end

	initial begin
		logic [22:0] radii[4];
		logic [31:0] la, oa;
		bit steady;
		sb = new();
		arc_tab = ATAN_TAB_64();
		clk = 1'b0;
		arst_n = 1'b0;
		req_valid = 1'b0;
		lat_a = '0;
		lon_a = '0;
		lat_b = '0;
		lon_b = '0;
		rsp_ready = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		radius = gcd_pkg::RADIUS_RST;
		n_sent = 0;
		rx_steady = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// same point, antipodes, poles, date line and full-turn longitude wrap
		send_points(0, 0, 0, 0);
		send_points(0, 0, 0, 32'h8000_0000);
		send_points(32'h4000_0000, 0, 32'hC000_0000, 0);
		send_points(32'h4000_0000, 32'h1234_5678, 32'h4000_0000, 32'h8765_4321);
		send_points(0, 32'h7FFF_FFFF, 0, 32'h8000_0000);
		send_points(0, 32'h8000_0000, 0, 32'h7FFF_FFFF);
		send_points(32'h1000_0000, 32'hF000_0000, 32'hF000_0000, 32'h1000_0000);
		send_points(32'h0000_0001, 0, 0, 1);
		send_points(32'h3FFF_FFFF, 0, 32'hC000_0001, 32'h8000_0000);
		send_points(32'h4000_0001, 0, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
		send_points(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000, 32'hAAAA_AAAA);
		send_points(32'h5555_5555, 32'h5555_5555, 32'hBFFF_FFFF, 32'h0000_0000);

		radii[0] = 23'd6000000;
		radii[1] = 23'd6500000;
		radii[2] = 23'h7FFFFF;
		radii[3] = 23'd6371000;
		// bring cfg_wdata through all ones and zeros as well
		drain_then_write(23'd0);
		send_points(0, 0, 0, 32'h8000_0000);
		drain_then_write(23'h7FFFFF);
		send_points(0, 0, 0, 32'h8000_0000);
		send_points(32'h4000_0000, 0, 32'hC000_0000, 0);
		for (int ph = 0; ph < 4; ph++) begin
			drain_then_write(radii[ph]);
			steady = (ph == 2);
			rx_steady = steady;
			for (int k = 0; k < N_RANDOM / 4; k++) begin
				la = rand_lat();
				oa = $urandom();
				if ($urandom_range(3) == 0) begin
					send_maybe_idle(la, oa, rand_lat() ^ 32'h1, oa + $urandom_range(4096), steady);
				end else begin
					send_maybe_idle(la, oa, rand_lat(), $urandom(), steady);
				end
			end
		end
		rx_steady = 1'b0;

		steps_wait();
		$display("Checked %0d distances over %0d radius settings, %0d point pairs sent.",
			sb.n_checked, 6, n_sent);
		if (sb.n_errors == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

	task automatic steps_wait();
		int guard;
		req_valid <= 1'b0;
		guard = 0;
		while (sb.pending_dist.size() != 0 && guard < 100000) begin
			@(posedge clk);
			guard++;
		end
		if (sb.pending_dist.size() != 0) begin
			$error("distance_m: %0d transactions never answered", sb.pending_dist.size());
			sb.n_errors++;
		end
		repeat (LATENCY + 10) @(posedge clk);
	endtask

	function automatic logic [63:0] ATAN_TAB_64_entry(int i);
		return 64'(signed'(gcd_pkg::ATAN_TAB[i]));
	endfunction

	typedef logic [63:0] arc_arr_t[32];

	function automatic arc_arr_t ATAN_TAB_64();
		arc_arr_t t;
		for (int i = 0; i < 32; i++) begin
			t[i] = ATAN_TAB_64_entry(i);
		end
		return t;
	endfunction
endmodule

// ===== great_circle_distance_core.f =====
hw/rtl/gcd_pkg.sv
hw/rtl/gcd_cordic_rot.sv
hw/rtl/gcd_cordic_vec.sv
hw/rtl/great_circle_distance_core.sv
hw/rtl/gcd_checker.sv
test/tb_top.sv
